// ===== sv/assert_macros.svh =====
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DFR_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define DFR_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("deframer assertion failed");

`endif

// ===== sv/dfr_pkg.sv =====
// Shared constants and types of the delimited frame receiver.
// No dependencies.
package dfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int BYTE_W           = 8;
  localparam int CNT_W            = 7;   // holds any payload count 0..64
  localparam int INDEX_W          = 6;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_BYTE   = 2'd2;

  localparam logic [CNT_W-1:0]  PAYLOAD_LENGTH_RST = 7'd6;
  localparam logic [BYTE_W-1:0] HEADER_BYTE_RST    = 8'h21;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE_RST   = 8'h23;

  // Read-out request from the frame parser to the drain unit.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } drain_req_t;

endpackage

// ===== sv/dfr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dfr_parser.sv =====
// Frame parser: header/trailer matching and payload writes into the RAM.
// Depends on dfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfr_parser #(
  parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [dfr_pkg::CNT_W-1:0]  payload_length,
  input  logic [dfr_pkg::BYTE_W-1:0] header_byte,
  input  logic [dfr_pkg::BYTE_W-1:0] trailer_byte,
  input  logic                       drain_busy,
  output logic                       ram_we,
  output logic [AW-1:0]              ram_waddr,
  output logic [dfr_pkg::BYTE_W-1:0] ram_wdata,
  output dfr_pkg::drain_req_t        drain_req
);

  localparam logic [2:0] PH_WAIT_H1 = 3'd0;
  localparam logic [2:0] PH_WAIT_H2 = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_TRL1    = 3'd3;
  localparam logic [2:0] PH_TRL2    = 3'd4;

  localparam logic [dfr_pkg::CNT_W-1:0] DEPTH_C = dfr_pkg::CNT_W'(BUFFER_DEPTH);

  logic [2:0]                phase, phase_next;
  logic [dfr_pkg::CNT_W-1:0] wpos, wpos_next;
  logic [dfr_pkg::CNT_W-1:0] act_len;
  logic [dfr_pkg::CNT_W-1:0] wpos_inc;
  logic                      acc;
  logic                      hdr_hit, trl_hit, room;

  assign in_ready = !drain_busy;
  assign acc      = in_valid && in_ready;
  assign hdr_hit  = (rx_byte == header_byte);
  assign trl_hit  = (rx_byte == trailer_byte);
  assign room     = (wpos < DEPTH_C);
  assign wpos_inc = room ? wpos + 1'b1 : wpos;

  // Saturate the programmed length to 1..BUFFER_DEPTH.
  always_comb begin
    if (payload_length == '0) begin
      act_len = dfr_pkg::CNT_W'(1);
    end else if (payload_length > DEPTH_C) begin
      act_len = DEPTH_C;
    end else begin
      act_len = payload_length;
    end
  end

  always_comb begin
    phase_next      = phase;
    wpos_next       = wpos;
    ram_we          = 1'b0;
    ram_waddr       = wpos[AW-1:0];
    ram_wdata       = rx_byte;
    drain_req.start = 1'b0;
    drain_req.count = wpos;
    if (acc) begin
      case (phase)
        PH_WAIT_H1: begin
          if (hdr_hit) begin
            wpos_next  = '0;
            phase_next = PH_WAIT_H2;
          end
        end
        PH_WAIT_H2: phase_next = hdr_hit ? PH_DATA : PH_WAIT_H1;
        PH_DATA: begin
          ram_we    = room;
          wpos_next = wpos_inc;
          if (wpos_inc >= act_len) begin
            phase_next = PH_TRL1;
          end
        end
        PH_TRL1: phase_next = trl_hit ? PH_TRL2 : PH_WAIT_H1;
        PH_TRL2: begin
          drain_req.start = trl_hit;
          phase_next      = PH_WAIT_H1;
        end
        default: phase_next = PH_WAIT_H1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT_H1;
      wpos  <= '0;
    end else begin
      phase <= phase_next;
      wpos  <= wpos_next;
    end
  end

  `DFR_ASSERT_IMP(a_data_has_room, phase == PH_DATA, wpos < DEPTH_C)
  `DFR_ASSERT_IMP(a_req_nonempty, drain_req.start, drain_req.count != '0)
  `DFR_ASSERT_NXT(a_header_clears_wpos, acc && phase == PH_WAIT_H1 && hdr_hit, wpos == '0)

endmodule

// ===== sv/dfr_drain.sv =====
// Drain unit: reads a completed payload out of the RAM into the output register.
// Depends on dfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfr_drain #(
  parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dfr_pkg::drain_req_t         drain_req,
  output logic                        busy,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [dfr_pkg::BYTE_W-1:0]  ram_rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dfr_pkg::BYTE_W-1:0]  payload_byte,
  output logic [dfr_pkg::INDEX_W-1:0] payload_index,
  output logic                        last
);

  logic [dfr_pkg::CNT_W-1:0]   rd_idx;
  logic [dfr_pkg::CNT_W-1:0]   count;
  logic                        rd_pend;
  logic [dfr_pkg::INDEX_W-1:0] pend_index;
  logic                        pend_last;
  logic                        issue;
  logic                        issue_last;

  // One read in flight at a time; the output register is free when it lands.
  assign issue      = busy && !rd_pend && (!out_valid || out_ready);
  assign issue_last = (rd_idx + 1'b1) == count;
  assign ram_re     = issue;
  assign ram_raddr  = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      rd_idx    <= '0;
    end else begin
      rd_pend <= issue;
      if (drain_req.start && drain_req.count != '0) begin
        busy   <= 1'b1;
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
        if (issue_last) begin
          busy <= 1'b0;
        end
      end
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_req.start) begin
      count <= drain_req.count;
    end
    if (issue) begin
      pend_index <= rd_idx[dfr_pkg::INDEX_W-1:0];
      pend_last  <= issue_last;
    end
    if (rd_pend) begin
      payload_byte  <= ram_rdata;
      payload_index <= pend_index;
      last          <= pend_last;
    end
  end

  `DFR_ASSERT_IMP(a_landing_slot_free, rd_pend, !out_valid)
  `DFR_ASSERT_IMP(a_issue_in_range, issue, rd_idx < count)
  `DFR_ASSERT_IMP(a_start_clean, $rose(busy), rd_idx == '0 && count != '0)

endmodule

// ===== sv/delimited_frame_receiver_core.sv =====
// Delimited frame receiver: finds header/payload/trailer frames in a byte stream.
// Depends on dfr_pkg, dfr_ram, dfr_parser and dfr_drain.
//
// Bytes arrive on rx_byte (valid/ready) and are matched against two header bytes,
// a fixed-length payload kept in an internal RAM, and two trailer bytes. On the
// second trailer byte the stored payload is read out as one request per byte on
// the output channel, with payload_index counting from 0 and last marking the
// final byte. A wrong second header or trailer byte drops back to header search
// without reusing that byte. Outside read-out the input is always ready. During
// read-out the input is held off; the RAM's single read port with its registered
// read allows one read in flight, so the next payload byte is read only
// after the previous read has landed and the output register can take it; the
// last byte is still bound for the output register when input resumes. The
// configuration port writes payload_length (saturated to 1..BUFFER_DEPTH),
// header_byte and trailer_byte; write it only while the block is idle.
module delimited_frame_receiver_core #(
  parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dfr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dfr_pkg::BYTE_W-1:0]    payload_byte,
  output logic [dfr_pkg::INDEX_W-1:0]   payload_index,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfr_pkg::BYTE_W-1:0]    cfg_data
);

  logic [dfr_pkg::CNT_W-1:0]  payload_length;
  logic [dfr_pkg::BYTE_W-1:0] header_byte;
  logic [dfr_pkg::BYTE_W-1:0] trailer_byte;

  logic                       drain_busy;
  dfr_pkg::drain_req_t        drain_req;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [dfr_pkg::BYTE_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [dfr_pkg::BYTE_W-1:0] ram_rdata;

  // Writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= dfr_pkg::PAYLOAD_LENGTH_RST;
      header_byte    <= dfr_pkg::HEADER_BYTE_RST;
      trailer_byte   <= dfr_pkg::TRAILER_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dfr_pkg::REG_PAYLOAD_LENGTH: payload_length <= cfg_data[dfr_pkg::CNT_W-1:0];
        dfr_pkg::REG_HEADER_BYTE:    header_byte    <= cfg_data;
        dfr_pkg::REG_TRAILER_BYTE:   trailer_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  dfr_parser #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .payload_length (payload_length),
    .header_byte    (header_byte),
    .trailer_byte   (trailer_byte),
    .drain_busy     (drain_busy),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .drain_req      (drain_req)
  );

  dfr_ram #(.WIDTH(dfr_pkg::BYTE_W), .DEPTH(BUFFER_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dfr_drain #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_drain (
    .clk           (clk),
    .rst           (rst),
    .drain_req     (drain_req),
    .busy          (drain_busy),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .last          (last)
  );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for delimited_frame_receiver_core: directed and random byte streams.
// Uses dfr_pkg for widths and register indexes; predicts payload read-out in SV.
`timescale 1ns / 1ps

module tb_top;

  localparam int BYTE_W    = dfr_pkg::BYTE_W;
  localparam int INDEX_W   = dfr_pkg::INDEX_W;
  localparam int CNT_W     = dfr_pkg::CNT_W;
  localparam int CFG_IDX_W = dfr_pkg::CFG_IDX_W;

  localparam int DEPTH        = dfr_pkg::BUFFER_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 240;

  localparam logic [2:0] SEEK_HDR1    = 3'd0;
  localparam logic [2:0] SEEK_HDR2    = 3'd1;
  localparam logic [2:0] FILL_PAYLOAD = 3'd2;
  localparam logic [2:0] SEEK_TRL1    = 3'd3;
  localparam logic [2:0] SEEK_TRL2    = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } payload_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    payload_byte;
  logic [INDEX_W-1:0]   payload_index;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = dfr_pkg::REG_PAYLOAD_LENGTH;
  logic [BYTE_W-1:0]    cfg_data = '0;

  // Predictor state
  logic [2:0]        hunt_phase = SEEK_HDR1;
  logic [CNT_W-1:0]  fill_count = '0;
  logic [BYTE_W-1:0] payload_mirror [0:DEPTH-1];
  logic [CNT_W-1:0]  len_reg = dfr_pkg::PAYLOAD_LENGTH_RST;
  logic [BYTE_W-1:0] hdr_reg = dfr_pkg::HEADER_BYTE_RST;
  logic [BYTE_W-1:0] trl_reg = dfr_pkg::TRAILER_BYTE_RST;

  payload_rec_t frame_bytes_due [$];
  int           mismatches = 0;
  int           sent_items = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           quiet = 1'b0;

  delimited_frame_receiver_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned len_in_use();
    int unsigned n;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  // Advance the deframer mirror by one accepted byte.
  task automatic deframe_predict(input logic [BYTE_W-1:0] b);
    payload_rec_t rec;
    case (hunt_phase)
      SEEK_HDR2: begin
        hunt_phase = (b == hdr_reg) ? FILL_PAYLOAD : SEEK_HDR1;
      end
      FILL_PAYLOAD: begin
        if (fill_count < DEPTH) begin
          payload_mirror[fill_count[INDEX_W-1:0]] = b;
          fill_count = fill_count + 1'b1;
        end
        if (fill_count >= len_in_use()) hunt_phase = SEEK_TRL1;
      end
      SEEK_TRL1: begin
        hunt_phase = (b == trl_reg) ? SEEK_TRL2 : SEEK_HDR1;
      end
      SEEK_TRL2: begin
        if (b == trl_reg) begin
          for (int k = 0; k < fill_count; k++) begin
            rec.data = payload_mirror[k[INDEX_W-1:0]];
            rec.idx  = k[INDEX_W-1:0];
            rec.last = (k + 1 == fill_count);
            frame_bytes_due.push_back(rec);
          end
        end
        hunt_phase = SEEK_HDR1;
      end
      default: begin
        if (b == hdr_reg) begin
          fill_count = '0;
          hunt_phase = SEEK_HDR2;
        end
      end
    endcase
  endtask

  // Receiver side: random stalls on out_ready.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    payload_rec_t exp_rec;
    if (!rst && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected payload request: byte %02h index %0d last %0b",
                 $time, payload_byte, payload_index, last);
        mismatches++;
      end else begin
        exp_rec = frame_bytes_due.pop_front();
        if (payload_byte !== exp_rec.data) begin
          $display("%0t: payload_byte expected %02h actual %02h",
                   $time, exp_rec.data, payload_byte);
          mismatches++;
        end
        if (payload_index !== exp_rec.idx) begin
          $display("%0t: payload_index expected %0d actual %0d",
                   $time, exp_rec.idx, payload_index);
          mismatches++;
        end
        if (last !== exp_rec.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_rec.last, last);
          mismatches++;
        end
      end
    end
  end

  task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    deframe_predict(b);
    sent_items++;
  endtask

  // Hold the sender until every payload request has arrived and the block settles.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dfr_pkg::REG_PAYLOAD_LENGTH: len_reg = val[CNT_W-1:0];
      dfr_pkg::REG_HEADER_BYTE:    hdr_reg = val;
      dfr_pkg::REG_TRAILER_BYTE:   trl_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_bytes(input logic [BYTE_W-1:0] seq [$]);
    foreach (seq[i]) send_rx_byte(seq[i]);
  endtask

  function automatic logic [BYTE_W-1:0] rand_payload_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return hdr_reg;
    if (r < 20) return trl_reg;
    if (r < 25) return 8'h00;
    if (r < 30) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // A wrong byte for a slot; often the header value, to show it is not reused.
  function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] x);
    logic [BYTE_W-1:0] v;
    if ($urandom_range(0, 1) == 1 && hdr_reg != x) return hdr_reg;
    do v = BYTE_W'($urandom_range(0, 255)); while (v == x);
    return v;
  endfunction

  task automatic send_random_frame();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = len_in_use();
    send_rx_byte(hdr_reg);
    if (r >= 70 && r < 80) begin
      send_rx_byte(other_than(hdr_reg));
      return;
    end
    send_rx_byte(hdr_reg);
    for (int k = 0; k < n; k++) send_rx_byte(rand_payload_byte());
    if (r >= 80 && r < 88) begin
      send_rx_byte(other_than(trl_reg));
      return;
    end
    send_rx_byte(trl_reg);
    if (r >= 88 && r < 96) begin
      send_rx_byte(other_than(trl_reg));
      return;
    end
    send_rx_byte(trl_reg);
  endtask

  task automatic test_default_frame();
    quiet = 1'b1;
    send_bytes('{8'h21, 8'h21, 8'h00, 8'hFF, 8'h21, 8'h23, 8'hAA, 8'h55, 8'h23, 8'h23});
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_broken_frames();
    write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, 8'd2);
    // wrong second header, then wrong first trailer equal to the header value
    send_bytes('{8'h21, 8'h7E, 8'h21, 8'h21, 8'h01, 8'h02, 8'h21,
                 8'h21, 8'h21, 8'h03, 8'h04, 8'h23, 8'h23});
    // wrong second trailer drops the frame
    send_bytes('{8'h21, 8'h21, 8'h05, 8'h06, 8'h23, 8'h21});
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, 8'd1);
    write_reg(dfr_pkg::REG_HEADER_BYTE, 8'h00);
    write_reg(dfr_pkg::REG_TRAILER_BYTE, 8'hFF);
    send_bytes('{8'h00, 8'h00, 8'h5A, 8'hFF, 8'hFF});
    wait_drained();
    // zero length acts as one
    write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, 8'd0);
    write_reg(dfr_pkg::REG_HEADER_BYTE, 8'hFF);
    write_reg(dfr_pkg::REG_TRAILER_BYTE, 8'h00);
    send_bytes('{8'hFF, 8'hFF, 8'hC3, 8'h00, 8'h00});
    wait_drained();
  endtask

  task automatic test_length_change();
    write_reg(dfr_pkg::REG_HEADER_BYTE, 8'h21);
    write_reg(dfr_pkg::REG_TRAILER_BYTE, 8'h23);
    write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, 8'd4);
    send_bytes('{8'h21, 8'h21, 8'h11, 8'h22, 8'h33});
    wait_drained();
    // shrink below the stored count: next byte ends the payload
    write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, 8'd2);
    send_bytes('{8'h44, 8'h23, 8'h23});
    wait_drained();
    send_bytes('{8'h21, 8'h21, 8'h55});
    wait_drained();
    write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, 8'd5);
    send_bytes('{8'h66, 8'h77, 8'h88, 8'h99, 8'h23, 8'h23});
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int start_items;
    int phase_start;
    int phase_no;
    logic [BYTE_W-1:0] len_val;
    logic [BYTE_W-1:0] hdr_val;
    logic [BYTE_W-1:0] trl_val;
    start_items = sent_items;
    phase_no = 0;
    while (sent_items - start_items < RANDOM_ITEMS) begin
      wait_drained();
      case (phase_no % 9)
        2:       len_val = 8'd64;
        5:       len_val = 8'hFF;  // masked to 127, saturates to the buffer depth
        7:       len_val = 8'h80;  // masked to 0, acts as one
        default: len_val = ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom_range(9, 20))
                                                         : BYTE_W'($urandom_range(1, 8));
      endcase
      hdr_val = BYTE_W'($urandom_range(0, 255));
      trl_val = (phase_no % 4 == 3) ? hdr_val : BYTE_W'($urandom_range(0, 255));
      write_reg(dfr_pkg::REG_PAYLOAD_LENGTH, len_val);
      write_reg(dfr_pkg::REG_HEADER_BYTE, hdr_val);
      write_reg(dfr_pkg::REG_TRAILER_BYTE, trl_val);
      quiet = (phase_no % 4 == 1);
      phase_start = sent_items;
      while (sent_items - phase_start < 30) begin
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 4)) send_rx_byte(rand_payload_byte());
        end
        send_random_frame();
      end
      phase_no++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frame();
    test_broken_frames();
    test_config_extremes();
    test_length_change();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dfr_pkg.sv
sv/dfr_ram.sv
sv/dfr_parser.sv
sv/dfr_drain.sv
sv/delimited_frame_receiver_core.sv
bench/tb_top.sv
